/* sv/nplc_pkg.sv */
`timescale 1ns / 1ps
package nplc_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int COORD_W    = 32;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [IDX_W-1:0]   id;
    } point_t;

    typedef struct packed {
        logic x_lt;
        logic x_eq;
        logic y_lt;
        logic y_eq;
        logic id_lt;
    } cmp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RK_RDI,
        S_RK_LDI,
        S_RK_RDJ,
        S_RK_CMP,
        S_RK_WR,
        S_L_RD,
        S_L_GET,
        S_L_TOP,
        S_L_BS,
        S_L_BSC,
        S_L_PUT,
        S_R_E,
        S_R_EG,
        S_R_RD,
        S_R_CHK,
        S_EMIT
    } state_t;

endpackage

/* sv/nplc_ram.sv */
`timescale 1ns / 1ps
module nplc_ram #(
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:(1<<ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/nplc_cmp.sv */
`timescale 1ns / 1ps
module nplc_cmp (
    input  nplc_pkg::point_t a,
    input  nplc_pkg::point_t b,
    output nplc_pkg::cmp_t   res
);

    always_comb
    begin
        res.x_lt  = a.x < b.x;
        res.x_eq  = a.x == b.x;
        res.y_lt  = a.y < b.y;
        res.y_eq  = a.y == b.y;
        res.id_lt = a.id < b.id;
    end

endmodule

/* sv/nested_pair_longest_chain_unit.sv */
`timescale 1ns / 1ps
// Longest strictly nested chain over a set of (x,y) pairs.
// Input channel: in_valid / in_stall with coord_x, coord_y, last_pair.
// Pairs are stored one per cycle while in_stall is low, in arrival order; pairs beyond 64 are dropped.
// The item with last_pair set starts the computation; in_stall stays high
// until every result of the set has been handed to the output register.
// Computation over the stored pairs runs in order: a ranking sort (each
// compare goes through the shared comparator after a registered memory
// read), the tails search, the backward rebuild and the emit scan.
// Output channel: out_valid / out_stall with chain_length, member_id,
// last_member; one item per chain member, ids ascending, last_member on the
// final one. A stalled output holds its item and pauses the emit scan.
// After the set is emitted the store is empty and the next set may load.
// Reset clears the pair count, the sequencer and the output register.
module nested_pair_longest_chain_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] coord_x,
    input  logic [31:0] coord_y,
    input  logic        last_pair,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  chain_length,
    output logic [6:0]  member_id,
    output logic        last_member
);

    localparam int IW = nplc_pkg::IDX_W;
    localparam int CW = nplc_pkg::CNT_W;
    localparam int PW = $bits(nplc_pkg::point_t);
    localparam int N  = nplc_pkg::MAX_POINTS;

    nplc_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [IW-1:0] rank_reg, rank_next;
    logic [CW-1:0] top_reg, top_next;
    logic [CW-1:0] best_reg, best_next;
    logic [IW-1:0] end_reg, end_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] want_reg, want_next;
    logic [N-1:0]  picked_reg, picked_next;
    nplc_pkg::point_t pi_reg, pi_next;
    nplc_pkg::point_t anc_reg, anc_next;
    logic [31:0]   cur_y_reg, cur_y_next;

    logic          ov_reg, ov_next;
    logic [6:0]    len_reg, len_next;
    logic [6:0]    mid_out_reg, mid_out_next;
    logic          lm_reg, lm_next;

    logic          raw_we;
    logic [IW-1:0] raw_waddr, raw_raddr;
    logic [63:0]   raw_rdata;
    logic          srt_we;
    logic [IW-1:0] srt_waddr, srt_raddr;
    nplc_pkg::point_t srt_wdata, srt_rdata;
    logic          tl_we;
    logic [IW-1:0] tl_waddr, tl_raddr;
    logic [31:0]   tl_rdata;
    logic          lv_we;
    logic [IW-1:0] lv_waddr, lv_raddr;
    logic [CW-1:0] lv_rdata;

    nplc_pkg::point_t cmp_a, cmp_b, raw_pt;
    nplc_pkg::cmp_t   cmp_res;

    logic in_acc, out_free, comes_before, full;
    logic [N-1:0] above_mask;

    nplc_ram #(.WIDTH(64), .ADDR_W(IW)) u_raw (
        .clk(clk), .we(raw_we), .waddr(raw_waddr), .wdata({coord_x, coord_y}),
        .raddr(raw_raddr), .rdata(raw_rdata)
    );
    nplc_ram #(.WIDTH(PW), .ADDR_W(IW)) u_srt (
        .clk(clk), .we(srt_we), .waddr(srt_waddr), .wdata(srt_wdata),
        .raddr(srt_raddr), .rdata(srt_rdata)
    );
    nplc_ram #(.WIDTH(32), .ADDR_W(IW)) u_tails (
        .clk(clk), .we(tl_we), .waddr(tl_waddr), .wdata(cur_y_reg),
        .raddr(tl_raddr), .rdata(tl_rdata)
    );
    nplc_ram #(.WIDTH(CW), .ADDR_W(IW)) u_level (
        .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lo_reg),
        .raddr(lv_raddr), .rdata(lv_rdata)
    );

    nplc_cmp u_cmp (.a(cmp_a), .b(cmp_b), .res(cmp_res));

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;
    assign full     = count_reg == CW'(N);
    assign raw_pt   = '{x: raw_rdata[63:32], y: raw_rdata[31:0], id: j_reg[IW-1:0]};
    assign comes_before = cmp_res.x_lt
        || (cmp_res.x_eq && ((!cmp_res.y_lt && !cmp_res.y_eq)
        || (cmp_res.y_eq && cmp_res.id_lt)));
    assign above_mask = ~((N'(2) << i_reg[IW-1:0]) - N'(1));

    assign out_valid    = ov_reg;
    assign chain_length = len_reg;
    assign member_id    = mid_out_reg;
    assign last_member  = lm_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nplc_pkg::S_IDLE:
                if (in_acc && last_pair)
                    state_next = nplc_pkg::S_RK_RDI;
            nplc_pkg::S_RK_RDI: state_next = nplc_pkg::S_RK_LDI;
            nplc_pkg::S_RK_LDI: state_next = nplc_pkg::S_RK_RDJ;
            nplc_pkg::S_RK_RDJ: state_next = nplc_pkg::S_RK_CMP;
            nplc_pkg::S_RK_CMP:
                state_next = (j_reg + CW'(1) == count_reg) ? nplc_pkg::S_RK_WR
                                                            : nplc_pkg::S_RK_RDJ;
            nplc_pkg::S_RK_WR:
                state_next = (i_reg + CW'(1) == count_reg) ? nplc_pkg::S_L_RD
                                                            : nplc_pkg::S_RK_RDI;
            nplc_pkg::S_L_RD:  state_next = nplc_pkg::S_L_GET;
            nplc_pkg::S_L_GET:
                state_next = (top_reg == '0) ? nplc_pkg::S_L_PUT : nplc_pkg::S_L_TOP;
            nplc_pkg::S_L_TOP:
                state_next = cmp_res.y_lt ? nplc_pkg::S_L_PUT : nplc_pkg::S_L_BS;
            nplc_pkg::S_L_BS:
                state_next = (lo_reg < hi_reg) ? nplc_pkg::S_L_BSC : nplc_pkg::S_L_PUT;
            nplc_pkg::S_L_BSC: state_next = nplc_pkg::S_L_BS;
            nplc_pkg::S_L_PUT:
                state_next = (i_reg + CW'(1) == count_reg) ? nplc_pkg::S_R_E
                                                            : nplc_pkg::S_L_RD;
            nplc_pkg::S_R_E:  state_next = nplc_pkg::S_R_EG;
            nplc_pkg::S_R_EG: state_next = nplc_pkg::S_R_RD;
            nplc_pkg::S_R_RD:
                state_next = (i_reg == '0 || want_reg <= CW'(1)) ? nplc_pkg::S_EMIT
                                                                 : nplc_pkg::S_R_CHK;
            nplc_pkg::S_R_CHK: state_next = nplc_pkg::S_R_RD;
            nplc_pkg::S_EMIT:
                if (i_reg == count_reg)
                    state_next = nplc_pkg::S_IDLE;
            default: state_next = nplc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = state_reg != nplc_pkg::S_IDLE;
        raw_we    = in_acc && !full;
        raw_waddr = count_reg[IW-1:0];
        raw_raddr = j_reg[IW-1:0];
        srt_we    = 1'b0;
        srt_waddr = rank_reg;
        srt_wdata = pi_reg;
        srt_raddr = i_reg[IW-1:0];
        tl_we     = 1'b0;
        tl_waddr  = IW'(lo_reg - CW'(1));
        tl_raddr  = IW'(top_reg - CW'(1));
        lv_we     = 1'b0;
        lv_waddr  = i_reg[IW-1:0];
        lv_raddr  = IW'(i_reg - CW'(1));
        cmp_a     = raw_pt;
        cmp_b     = pi_reg;
        case (state_reg)
            nplc_pkg::S_RK_RDI: raw_raddr = i_reg[IW-1:0];
            nplc_pkg::S_RK_WR:  srt_we = 1'b1;
            nplc_pkg::S_L_TOP:
            begin
                cmp_a = '{x: '0, y: tl_rdata, id: '0};
                cmp_b = '{x: '0, y: cur_y_reg, id: '0};
            end
            nplc_pkg::S_L_BS:   tl_raddr = IW'(lo_reg + ((hi_reg - lo_reg) >> 1) - CW'(1));
            nplc_pkg::S_L_BSC:
            begin
                cmp_a = '{x: '0, y: tl_rdata, id: '0};
                cmp_b = '{x: '0, y: cur_y_reg, id: '0};
            end
            nplc_pkg::S_L_PUT:
            begin
                tl_we = 1'b1;
                lv_we = 1'b1;
            end
            nplc_pkg::S_R_E:    srt_raddr = end_reg;
            nplc_pkg::S_R_RD:   srt_raddr = IW'(i_reg - CW'(1));
            nplc_pkg::S_R_CHK:
            begin
                cmp_a = srt_rdata;
                cmp_b = anc_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        rank_next    = rank_reg;
        top_next     = top_reg;
        best_next    = best_reg;
        end_next     = end_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        want_next    = want_reg;
        picked_next  = picked_reg;
        pi_next      = pi_reg;
        anc_next     = anc_reg;
        cur_y_next   = cur_y_reg;
        ov_next      = ov_reg && out_stall;
        len_next     = len_reg;
        mid_out_next = mid_out_reg;
        lm_next      = lm_reg;
        case (state_reg)
            nplc_pkg::S_IDLE:
            begin
                i_next = '0;
                if (in_acc && !full)
                    count_next = count_reg + CW'(1);
            end
            nplc_pkg::S_RK_LDI:
            begin
                pi_next   = '{x: raw_rdata[63:32], y: raw_rdata[31:0], id: i_reg[IW-1:0]};
                j_next    = '0;
                rank_next = '0;
            end
            nplc_pkg::S_RK_CMP:
            begin
                if (comes_before)
                    rank_next = rank_reg + IW'(1);
                j_next = j_reg + CW'(1);
            end
            nplc_pkg::S_RK_WR:
            begin
                if (i_reg + CW'(1) == count_reg)
                begin
                    i_next    = '0;
                    top_next  = '0;
                    best_next = '0;
                    end_next  = '0;
                end
                else
                    i_next = i_reg + CW'(1);
            end
            nplc_pkg::S_L_GET:
            begin
                cur_y_next = srt_rdata.y;
                if (top_reg == '0)
                begin
                    top_next = CW'(1);
                    lo_next  = CW'(1);
                end
            end
            nplc_pkg::S_L_TOP:
            begin
                if (cmp_res.y_lt)
                begin
                    top_next = top_reg + CW'(1);
                    lo_next  = top_reg + CW'(1);
                end
                else
                begin
                    lo_next = CW'(1);
                    hi_next = top_reg;
                end
            end
            nplc_pkg::S_L_BS:   mid_next = lo_reg + ((hi_reg - lo_reg) >> 1);
            nplc_pkg::S_L_BSC:
            begin
                if (cmp_res.y_lt)
                    lo_next = mid_reg + CW'(1);
                else
                    hi_next = mid_reg;
            end
            nplc_pkg::S_L_PUT:
            begin
                if (lo_reg > best_reg)
                begin
                    best_next = lo_reg;
                    end_next  = i_reg[IW-1:0];
                end
                i_next = i_reg + CW'(1);
            end
            nplc_pkg::S_R_E:    picked_next = '0;
            nplc_pkg::S_R_EG:
            begin
                anc_next = srt_rdata;
                picked_next[srt_rdata.id] = 1'b1;
                want_next = best_reg;
                i_next    = count_reg;
            end
            nplc_pkg::S_R_RD:
                if (i_reg == '0 || want_reg <= CW'(1))
                    i_next = '0;
            nplc_pkg::S_R_CHK:
            begin
                if (lv_rdata == want_reg - CW'(1) && cmp_res.x_lt && cmp_res.y_lt)
                begin
                    picked_next[srt_rdata.id] = 1'b1;
                    anc_next  = srt_rdata;
                    want_next = want_reg - CW'(1);
                end
                i_next = i_reg - CW'(1);
            end
            nplc_pkg::S_EMIT:
            begin
                if (i_reg == count_reg)
                    count_next = '0;
                else if (!picked_reg[i_reg[IW-1:0]])
                    i_next = i_reg + CW'(1);
                else if (out_free)
                begin
                    ov_next      = 1'b1;
                    len_next     = best_reg;
                    mid_out_next = i_reg + CW'(1);
                    lm_next      = (picked_reg & above_mask) == '0;
                    i_next       = i_reg + CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= nplc_pkg::S_IDLE;
            count_reg   <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            rank_reg    <= '0;
            top_reg     <= '0;
            best_reg    <= '0;
            end_reg     <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            mid_reg     <= '0;
            want_reg    <= '0;
            picked_reg  <= '0;
            ov_reg      <= 1'b0;
            len_reg     <= '0;
            mid_out_reg <= '0;
            lm_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            rank_reg    <= rank_next;
            top_reg     <= top_next;
            best_reg    <= best_next;
            end_reg     <= end_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            mid_reg     <= mid_next;
            want_reg    <= want_next;
            picked_reg  <= picked_next;
            ov_reg      <= ov_next;
            len_reg     <= len_next;
            mid_out_reg <= mid_out_next;
            lm_reg      <= lm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pi_reg    <= pi_next;
        anc_reg   <= anc_next;
        cur_y_reg <= cur_y_next;
    end

endmodule
